/* design/crtf_pkg.sv */
// ----------------------------------------------------------------------------
// crtf_pkg
// Shared types, constants and the prebuffer table for the compressed RTF
// LZ decompressor.
// ----------------------------------------------------------------------------
package crtf_pkg;

  localparam int DictDepth = 4096;
  localparam int AddrW     = 12;
  localparam int PrebufLen = 207;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_COPY
  } crtf_state_e;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TOKEN,
    PH_REFLO
  } crtf_phase_e;

  typedef enum logic {
    REG_MODE,
    REG_RAW_SIZE
  } crtf_reg_e;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } crtf_wr_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
  } crtf_rd_t;

  localparam logic [8*PrebufLen-1:0] PREBUF = {
    "{\\rtf1\\ansi\\mac\\deff0\\deftab720{\\fonttbl;}",
    "{\\f0\\fnil \\froman \\fswiss \\fmodern \\fscript ",
    "\\fdecor MS Sans SerifSymbolArialTimes New RomanCourier",
    "{\\colortbl\\red0\\green0\\blue0\012\015\\par ",
    "\\pard\\plain\\f0\\fs20\\b\\i\\u\\tab\\tx"
  };

  function automatic logic [7:0] prebuf_byte(input logic [AddrW-1:0] addr);
    int idx;
    logic [7:0] res;
    idx = int'(addr);
    res = 8'h00;
    if (idx < PrebufLen) begin
      res = PREBUF[(PrebufLen - 1 - idx) * 8 +: 8];
    end
    return res;
  endfunction

endpackage

/* design/crtf_dict_ram.sv */
// ----------------------------------------------------------------------------
// crtf_dict_ram
// Dictionary ring: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module crtf_dict_ram (
  input  logic               clk_i,
  input  crtf_pkg::crtf_wr_t wr_i,
  input  crtf_pkg::crtf_rd_t rd_i,
  output logic [7:0]         rd_data_o
);

  logic [7:0] mem [crtf_pkg::DictDepth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/compressed_rtf_lz_decompressor_unit.sv */
// ----------------------------------------------------------------------------
// compressed_rtf_lz_decompressor_unit
// Decodes the LZ payload of compressed RTF one input word at a time through
// a 4096-byte dictionary ring, or passes words through in copy mode.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o | in_byte_i
//   out     | output    | out_valid_o / out_stall_i | out_byte_o, byte_valid_o,
//           |           |                        | run_last_o, stream_done_o
//   cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// Flag, literal, reference high byte and pass-through words leave the unit
// idle, as do the reference low byte that ends the stream and words after
// the end. A copying reference low byte writes 2 to 17 bytes; the dictionary
// port delivers one byte per cycle while the output is not stalled, one
// read ahead of the write. After reset a pass loads the prebuffer and zeros
// into the ring; no word is accepted meanwhile, configuration writes are.
// A stalled output holds the copy in place and holds off the input.
// ----------------------------------------------------------------------------
module compressed_rtf_lz_decompressor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        run_last_o,
  output logic        stream_done_o
);

  localparam int AW = crtf_pkg::AddrW;

  crtf_pkg::crtf_state_e state_q, state_d;
  crtf_pkg::crtf_phase_e phase_q, phase_d;

  logic          mode_q;
  logic [31:0]   raw_q;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [7:0]    flag_q, flag_d;
  logic [2:0]    idx_q, idx_d;
  logic [7:0]    ref_hi_q, ref_hi_d;
  logic [31:0]   cnt_q, cnt_d;
  logic          finished_q, finished_d;
  logic [AW-1:0] rd_pos_q, rd_pos_d;
  logic [4:0]    rd_left_q, rd_left_d;
  logic [4:0]    wr_left_q, wr_left_d;
  logic          fwd_q, fwd_d;
  logic [7:0]    fwd_data_q, fwd_data_d;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          byte_valid_q, byte_valid_d;
  logic          run_last_q, run_last_d;
  logic          done_q, done_d;

  crtf_pkg::crtf_wr_t wr;
  crtf_pkg::crtf_rd_t rd;
  logic [7:0]         rd_data;

  logic          slot_free;
  logic          accept;
  logic [AW-1:0] ref_pos;
  logic          end_hit;
  logic          under;
  logic          last_room;
  logic [7:0]    copy_byte;
  logic [2:0]    idx_inc;

  crtf_dict_ram u_dict (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_i      (rd),
    .rd_data_o (rd_data)
  );

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == crtf_pkg::ST_IDLE) && slot_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign ref_pos    = {ref_hi_q, in_byte_i[7:4]};
  assign end_hit    = (ref_pos == wp_q);
  assign under      = (cnt_q < raw_q);
  assign last_room  = ((cnt_q + 32'd1) == raw_q);
  assign copy_byte  = fwd_q ? fwd_data_q : rd_data;
  assign idx_inc    = idx_q + 3'd1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      crtf_pkg::ST_INIT: begin
        if (clr_q == AW'(crtf_pkg::DictDepth - 1)) begin
          state_d = crtf_pkg::ST_IDLE;
        end
      end
      crtf_pkg::ST_IDLE: begin
        if (accept && mode_q && !finished_q && phase_q == crtf_pkg::PH_REFLO && !end_hit) begin
          state_d = crtf_pkg::ST_COPY;
        end
      end
      crtf_pkg::ST_COPY: begin
        if (slot_free && wr_left_q == 5'd1) begin
          state_d = crtf_pkg::ST_IDLE;
        end
      end
      default: state_d = crtf_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    clr_d        = clr_q;
    wp_d         = wp_q;
    phase_d      = phase_q;
    flag_d       = flag_q;
    idx_d        = idx_q;
    ref_hi_d     = ref_hi_q;
    cnt_d        = cnt_q;
    finished_d   = finished_q;
    rd_pos_d     = rd_pos_q;
    rd_left_d    = rd_left_q;
    wr_left_d    = wr_left_q;
    fwd_d        = fwd_q;
    fwd_data_d   = fwd_data_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_byte_d   = out_byte_q;
    byte_valid_d = byte_valid_q;
    run_last_d   = run_last_q;
    done_d       = done_q;
    wr           = '0;
    rd           = '0;

    unique case (state_q)
      crtf_pkg::ST_INIT: begin
        wr.en   = 1'b1;
        wr.addr = clr_q;
        wr.data = crtf_pkg::prebuf_byte(clr_q);
        clr_d   = clr_q + AW'(1);
      end
      crtf_pkg::ST_IDLE: begin
        if (accept && !finished_q) begin
          if (!mode_q) begin
            if (under) begin
              cnt_d        = cnt_q + 32'd1;
              out_valid_d  = 1'b1;
              out_byte_d   = in_byte_i;
              byte_valid_d = 1'b1;
              run_last_d   = 1'b1;
              done_d       = 1'b0;
            end
          end else begin
            unique case (phase_q)
              crtf_pkg::PH_FLAG: begin
                flag_d  = in_byte_i;
                idx_d   = 3'd0;
                phase_d = crtf_pkg::PH_TOKEN;
              end
              crtf_pkg::PH_TOKEN: begin
                if (!flag_q[idx_q]) begin
                  wr.en   = 1'b1;
                  wr.addr = wp_q;
                  wr.data = in_byte_i;
                  wp_d    = wp_q + AW'(1);
                  if (under) begin
                    cnt_d        = cnt_q + 32'd1;
                    out_valid_d  = 1'b1;
                    out_byte_d   = in_byte_i;
                    byte_valid_d = 1'b1;
                    run_last_d   = 1'b1;
                    done_d       = 1'b0;
                  end
                  idx_d   = idx_inc;
                  phase_d = (idx_inc == 3'd0) ? crtf_pkg::PH_FLAG : crtf_pkg::PH_TOKEN;
                end else begin
                  ref_hi_d = in_byte_i;
                  phase_d  = crtf_pkg::PH_REFLO;
                end
              end
              crtf_pkg::PH_REFLO: begin
                if (end_hit) begin
                  finished_d   = 1'b1;
                  phase_d      = crtf_pkg::PH_FLAG;
                  out_valid_d  = 1'b1;
                  out_byte_d   = 8'h00;
                  byte_valid_d = 1'b0;
                  run_last_d   = 1'b1;
                  done_d       = 1'b1;
                end else begin
                  rd.en      = 1'b1;
                  rd.addr    = ref_pos;
                  rd_pos_d   = ref_pos + AW'(1);
                  wr_left_d  = {1'b0, in_byte_i[3:0]} + 5'd2;
                  rd_left_d  = {1'b0, in_byte_i[3:0]} + 5'd1;
                  fwd_d      = 1'b0;
                end
              end
              default: phase_d = crtf_pkg::PH_FLAG;
            endcase
          end
        end
      end
      crtf_pkg::ST_COPY: begin
        if (slot_free) begin
          wr.en     = 1'b1;
          wr.addr   = wp_q;
          wr.data   = copy_byte;
          wp_d      = wp_q + AW'(1);
          wr_left_d = wr_left_q - 5'd1;
          if (under) begin
            cnt_d        = cnt_q + 32'd1;
            out_valid_d  = 1'b1;
            out_byte_d   = copy_byte;
            byte_valid_d = 1'b1;
            run_last_d   = (wr_left_q == 5'd1) || last_room;
            done_d       = 1'b0;
          end
          if (rd_left_q != 5'd0) begin
            rd.en      = 1'b1;
            rd.addr    = rd_pos_q;
            rd_pos_d   = rd_pos_q + AW'(1);
            rd_left_d  = rd_left_q - 5'd1;
            fwd_d      = (rd_pos_q == wp_q);
            fwd_data_d = copy_byte;
          end
          if (wr_left_q == 5'd1) begin
            idx_d   = idx_inc;
            phase_d = (idx_inc == 3'd0) ? crtf_pkg::PH_FLAG : crtf_pkg::PH_TOKEN;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      raw_q  <= 32'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        crtf_pkg::REG_MODE:     mode_q <= cfg_data_i[0];
        crtf_pkg::REG_RAW_SIZE: raw_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crtf_pkg::ST_INIT;
      phase_q     <= crtf_pkg::PH_FLAG;
      clr_q       <= '0;
      wp_q        <= AW'(crtf_pkg::PrebufLen);
      flag_q      <= '0;
      idx_q       <= '0;
      ref_hi_q    <= '0;
      cnt_q       <= '0;
      finished_q  <= 1'b0;
      rd_left_q   <= '0;
      wr_left_q   <= '0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      clr_q       <= clr_d;
      wp_q        <= wp_d;
      flag_q      <= flag_d;
      idx_q       <= idx_d;
      ref_hi_q    <= ref_hi_d;
      cnt_q       <= cnt_d;
      finished_q  <= finished_d;
      rd_left_q   <= rd_left_d;
      wr_left_q   <= wr_left_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pos_q     <= rd_pos_d;
    fwd_data_q   <= fwd_data_d;
    out_byte_q   <= out_byte_d;
    byte_valid_q <= byte_valid_d;
    run_last_q   <= run_last_d;
    done_q       <= done_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign byte_valid_o  = byte_valid_q;
  assign run_last_o    = run_last_q;
  assign stream_done_o = done_q;

  a_copy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == crtf_pkg::ST_COPY) |-> in_stall_o)
    else $error("input accepted during a copy");

  a_read_leads_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == crtf_pkg::ST_COPY) |-> (wr_left_q == rd_left_q + 5'd1))
    else $error("dictionary read and write out of step");

  a_end_marker_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> (!byte_valid_q && run_last_q && out_byte_q == 8'h00))
    else $error("malformed end marker");

  a_finished_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |=> (finished_q && !wr.en))
    else $error("ring modified after end of stream");

endmodule

/* tb/tb_compressed_rtf_lz_decompressor_unit.sv */
// ----------------------------------------------------------------------------
// tb_compressed_rtf_lz_decompressor_unit
// Self-checking bench for the compressed RTF LZ decompressor. An opening
// table of words (flag bytes, literals, plain and self-overlapping
// references, ring wrap on read, copy mode and a mode change inside a
// reference) is followed by random well-formed token streams over changing
// modes and output limits. The run closes with a reference cut short by the
// output limit, the end-of-stream reference and words sent after it. Every
// accepted word goes through a local decoder with its own ring, and every
// output word is checked field by field against the oldest awaited result.
// ----------------------------------------------------------------------------
module tb_compressed_rtf_lz_decompressor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD  = 6;
  localparam int DRAIN_CYCLES = 24;
  localparam int QUIET_LIMIT  = 25000;
  localparam int RANDOM_WORDS = 300;

  localparam logic [8*crtf_pkg::PrebufLen-1:0] RTF_PREAMBLE = {
    "{\\rtf1\\ansi\\mac\\deff0\\deftab720{\\fonttbl;}",
    "{\\f0\\fnil \\froman \\fswiss \\fmodern \\fscript ",
    "\\fdecor MS Sans SerifSymbolArialTimes New RomanCourier",
    "{\\colortbl\\red0\\green0\\blue0\012\015\\par ",
    "\\pard\\plain\\f0\\fs20\\b\\i\\u\\tab\\tx"
  };

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       done;
  } rtf_byte_t;

  typedef enum logic {
    ROW_WORD,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    crtf_pkg::crtf_reg_e idx;
    logic [31:0]         val;
    logic                typed;
    logic                has_res;
    rtf_byte_t           res;
  } plan_row_t;

  localparam rtf_byte_t NO_RES = '0;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = 1'b0;
  logic [31:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o;
  logic        run_last_o;
  logic        stream_done_o;

  // decoder state
  logic                        mode_q      = 1'b1;
  logic [31:0]                 raw_size_q  = '0;
  logic [7:0]                  ring [crtf_pkg::DictDepth];
  logic [crtf_pkg::AddrW-1:0]  wr_ptr_q    = crtf_pkg::AddrW'(crtf_pkg::PrebufLen);
  logic [7:0]                  flags_q     = '0;
  logic [2:0]                  flag_idx_q  = '0;
  crtf_pkg::crtf_phase_e       phase_q     = crtf_pkg::PH_FLAG;
  logic [7:0]                  ref_hi_q    = '0;
  logic [31:0]                 emitted_cnt = '0;
  logic                        stream_over = 1'b0;

  logic [crtf_pkg::AddrW-1:0] plan_pos = '0;
  rtf_byte_t                  fresh_bytes[$];
  rtf_byte_t                  awaited_bytes[$];
  rtf_byte_t                  want;
  int                         mismatches  = 0;
  int                         quiet       = 0;
  int                         stall_left  = 0;
  bit                         calm        = 1'b0;

  plan_row_t opening_rows [19] = '{
    '{ROW_WORD, crtf_pkg::REG_MODE,     32'h0000_00F8, 1'b1, 1'b0, NO_RES},
    '{ROW_WORD, crtf_pkg::REG_MODE,     32'h0000_00FF, 1'b1, 1'b0, NO_RES},
    '{ROW_REG,  crtf_pkg::REG_RAW_SIZE, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, crtf_pkg::REG_MODE,     32'h0000_0000, 1'b1, 1'b1,
      '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{ROW_WORD, crtf_pkg::REG_MODE,     32'h0000_0041, 1'b1, 1'b1,
      '{8'h41, 1'b1, 1'b1, 1'b0}},
    '{ROW_WORD, crtf_pkg::REG_MODE,     32'h0000_0000, 1'b1, 1'b0, NO_RES},
    '{ROW_WORD, crtf_pkg::REG_MODE,     32'h0000_000F, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, crtf_pkg::REG_MODE,     32'h0000_000E, 1'b1, 1'b0, NO_RES},
    '{ROW_WORD, crtf_pkg::REG_MODE,     32'h0000_002F, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, crtf_pkg::REG_MODE,     32'h0000_00FF, 1'b1, 1'b0, NO_RES},
    '{ROW_WORD, crtf_pkg::REG_MODE,     32'h0000_00F0, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, crtf_pkg::REG_MODE,     32'h0000_0001, 1'b1, 1'b0, NO_RES},
    '{ROW_REG,  crtf_pkg::REG_MODE,     32'hFFFF_FFFE, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, crtf_pkg::REG_MODE,     32'h0000_00FF, 1'b1, 1'b1,
      '{8'hFF, 1'b1, 1'b1, 1'b0}},
    '{ROW_WORD, crtf_pkg::REG_MODE,     32'h0000_0000, 1'b1, 1'b1,
      '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{ROW_REG,  crtf_pkg::REG_MODE,     32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, crtf_pkg::REG_MODE,     32'h0000_0035, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, crtf_pkg::REG_MODE,     32'h0000_000A, 1'b1, 1'b0, NO_RES},
    '{ROW_WORD, crtf_pkg::REG_MODE,     32'h0000_0000, 1'b0, 1'b0, NO_RES}
  };

  compressed_rtf_lz_decompressor_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .run_last_o    (run_last_o),
    .stream_done_o (stream_done_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic void add_fresh(input rtf_byte_t b);
    fresh_bytes.insert(fresh_bytes.size(), b);
  endfunction

  function automatic void add_awaited(input rtf_byte_t b);
    awaited_bytes.insert(awaited_bytes.size(), b);
  endfunction

  function automatic void ring_put(input logic [7:0] c);
    ring[wr_ptr_q] = c;
    wr_ptr_q       = wr_ptr_q + 1'b1;
  endfunction

  function automatic void emit_byte(input logic [7:0] c);
    if (emitted_cnt < raw_size_q) begin
      emitted_cnt = emitted_cnt + 32'd1;
      add_fresh(rtf_byte_t'{c, 1'b1, 1'b0, 1'b0});
    end
  endfunction

  function automatic void next_token();
    flag_idx_q = flag_idx_q + 1'b1;
    phase_q    = (flag_idx_q == 3'd0) ? crtf_pkg::PH_FLAG : crtf_pkg::PH_TOKEN;
  endfunction

  function automatic void decode_word(input logic [7:0] w);
    logic [crtf_pkg::AddrW-1:0] pos;
    logic [7:0]                 c;
    int                         len;
    fresh_bytes.delete();
    if (stream_over) return;
    if (!mode_q) begin
      emit_byte(w);
    end else begin
      case (phase_q)
        crtf_pkg::PH_FLAG: begin
          flags_q    = w;
          flag_idx_q = 3'd0;
          phase_q    = crtf_pkg::PH_TOKEN;
        end
        crtf_pkg::PH_TOKEN: begin
          if (!flags_q[flag_idx_q]) begin
            ring_put(w);
            emit_byte(w);
            next_token();
          end else begin
            ref_hi_q = w;
            phase_q  = crtf_pkg::PH_REFLO;
          end
        end
        default: begin
          pos = {ref_hi_q, w[7:4]};
          len = int'(w[3:0]) + 2;
          if (pos == wr_ptr_q) begin
            stream_over = 1'b1;
            phase_q     = crtf_pkg::PH_FLAG;
            add_fresh(rtf_byte_t'{8'h00, 1'b0, 1'b0, 1'b1});
          end else begin
            repeat (len) begin
              c = ring[pos];
              ring_put(c);
              emit_byte(c);
              pos = pos + 1'b1;
            end
            next_token();
          end
        end
      endcase
    end
    if (fresh_bytes.size() != 0) fresh_bytes[fresh_bytes.size() - 1].last = 1'b1;
  endfunction

  // well-formed token stream with random content; never ends the stream
  function automatic logic [7:0] pick_word();
    logic [7:0]                 w;
    logic [crtf_pkg::AddrW-1:0] p;
    w = 8'($urandom);
    if (!mode_q || stream_over) return w;
    case (phase_q)
      crtf_pkg::PH_FLAG: begin
        case ($urandom_range(0, 5))
          0:       w = 8'h00;
          1:       w = 8'hFF;
          default: ;
        endcase
      end
      crtf_pkg::PH_TOKEN: begin
        if (flags_q[flag_idx_q]) begin
          case ($urandom_range(0, 3))
            0:       p = wr_ptr_q - crtf_pkg::AddrW'($urandom_range(1, 16));
            1:       p = crtf_pkg::AddrW'($urandom_range(0, crtf_pkg::PrebufLen - 1));
            2:       p = crtf_pkg::AddrW'($urandom_range(crtf_pkg::DictDepth - 16,
                                                         crtf_pkg::DictDepth - 1));
            default: p = crtf_pkg::AddrW'($urandom);
          endcase
          if (p == wr_ptr_q) p = p + 1'b1;
          plan_pos = p;
          w        = p[11:4];
        end
      end
      default: begin
        w[7:4] = plan_pos[3:0];
        if ({ref_hi_q, w[7:4]} == wr_ptr_q) w[7:4] = w[7:4] + 1'b1;
      end
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic send_word(input logic [7:0] w, input logic typed, input logic has_res,
                           input rtf_byte_t res);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= w;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    decode_word(w);
    if (typed) begin
      if (has_res) add_awaited(res);
    end else begin
      foreach (fresh_bytes[k]) add_awaited(fresh_bytes[k]);
    end
  endtask

  task automatic write_reg(input crtf_pkg::crtf_reg_e idx, input logic [31:0] val);
    in_valid_i <= 1'b0;
    while (awaited_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == crtf_pkg::REG_MODE) mode_q = val[0];
    else raw_size_q = val;
  endtask

  always @(posedge clk_i) begin
    if (stall_left == 0 && !calm && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 3);
    out_stall_i <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected word %02h", out_byte_o));
      end else begin
        want = awaited_bytes.pop_front();
        if (out_byte_o !== want.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte_o, want.data));
        if (byte_valid_o !== want.valid)
          report_mismatch($sformatf("byte_valid %b, want %b", byte_valid_o, want.valid));
        if (run_last_o !== want.last)
          report_mismatch($sformatf("run_last %b, want %b", run_last_o, want.last));
        if (stream_done_o !== want.done)
          report_mismatch($sformatf("stream_done %b, want %b", stream_done_o, want.done));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int                         words_sent;
    int                         stretch;
    logic                       mode_pick;
    logic [crtf_pkg::AddrW-1:0] tail_pos;
    for (int i = 0; i < crtf_pkg::DictDepth; i++)
      ring[i] = (i < crtf_pkg::PrebufLen) ?
                RTF_PREAMBLE[(crtf_pkg::PrebufLen - 1 - i) * 8 +: 8] : 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening_rows[r]) begin
      if (opening_rows[r].kind == ROW_REG) begin
        write_reg(opening_rows[r].idx, opening_rows[r].val);
      end else begin
        send_word(opening_rows[r].val[7:0], opening_rows[r].typed, opening_rows[r].has_res,
                  opening_rows[r].res);
      end
    end

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      calm      = (words_sent > RANDOM_WORDS - 40) || ($urandom_range(0, 3) == 0);
      mode_pick = ($urandom_range(0, 5) != 0);
      if (mode_pick != mode_q) write_reg(crtf_pkg::REG_MODE, {31'($urandom), mode_pick});
      if ($urandom_range(0, 4) == 0)
        write_reg(crtf_pkg::REG_RAW_SIZE, emitted_cnt + 32'($urandom_range(0, 24)));
      else if (raw_size_q != 32'hFFFF_FFFF)
        write_reg(crtf_pkg::REG_RAW_SIZE, 32'hFFFF_FFFF);
      stretch = $urandom_range(4, 40);
      repeat (stretch) begin
        send_word(pick_word(), 1'b0, 1'b0, NO_RES);
        words_sent++;
      end
    end

    // cut a reference short at the output limit, then end the stream
    calm = 1'b1;
    if (!mode_q) write_reg(crtf_pkg::REG_MODE, 32'd1);
    while (phase_q != crtf_pkg::PH_FLAG) send_word(pick_word(), 1'b0, 1'b0, NO_RES);
    write_reg(crtf_pkg::REG_RAW_SIZE, emitted_cnt + 32'd5);
    tail_pos = wr_ptr_q - crtf_pkg::AddrW'(20);
    send_word(8'h03, 1'b0, 1'b0, NO_RES);
    send_word(tail_pos[11:4], 1'b0, 1'b0, NO_RES);
    send_word({tail_pos[3:0], 4'hF}, 1'b0, 1'b0, NO_RES);
    send_word(wr_ptr_q[11:4], 1'b0, 1'b0, NO_RES);
    send_word({wr_ptr_q[3:0], 4'($urandom)}, 1'b0, 1'b0, NO_RES);
    repeat (2) send_word(8'($urandom), 1'b0, 1'b0, NO_RES);
    write_reg(crtf_pkg::REG_MODE, 32'd0);
    repeat (2) send_word(8'($urandom), 1'b0, 1'b0, NO_RES);
    in_valid_i <= 1'b0;

    while (awaited_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
